// ===== design/lgs_pkg.sv =====
// shared types and constants for the life grid generation step
`default_nettype none
package lgs_pkg;

  localparam int MAX_ROWS_DEF = 256;
  localparam int MAX_COLS_DEF = 256;

  localparam logic [8:0] ROWS_RESET = 9'd200;
  localparam logic [8:0] COLS_RESET = 9'd200;

  localparam logic [3:0] BIRTH_COUNT = 4'd3;
  localparam logic [3:0] SURVIVE_MIN = 4'd2;

  localparam logic [1:0] CELL_EMPTY    = 2'd0;
  localparam logic [1:0] CELL_ALIVE    = 2'd1;
  localparam logic [1:0] CELL_IMMORTAL = 2'd2;

  localparam logic [1:0] FUNC_WRITE   = 2'd0;
  localparam logic [1:0] FUNC_READ    = 2'd1;
  localparam logic [1:0] FUNC_ADVANCE = 2'd2;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_OP,
    ST_ADV
  } state_t;

  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== design/lgs_ram.sv =====
// generic two-port ram with registered read
`default_nettype none
module lgs_ram #(
  parameter int WIDTH = 512,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== design/lgs_cell.sv =====
// one column cell: three-row window and the b3/s23 update
`default_nettype none
module lgs_cell (
  input  wire logic               clk,
  input  wire lgs_pkg::cell_ctrl_t ctrl,
  input  wire logic               active,
  input  wire logic [1:0]         in_value,
  input  wire logic [2:0]         left_live,
  input  wire logic [2:0]         right_live,
  output logic      [2:0]         live,
  output logic      [1:0]         next_value
);
  import lgs_pkg::*;

  logic [1:0] above_r;
  logic [1:0] cur_r;
  logic [1:0] below_r;
  logic [3:0] count;

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      above_r <= CELL_EMPTY;
      cur_r   <= CELL_EMPTY;
      below_r <= CELL_EMPTY;
    end else if (ctrl.shift) begin
      above_r <= cur_r;
      cur_r   <= below_r;
      below_r <= in_value;
    end
  end

  assign live = active ? {above_r != CELL_EMPTY, cur_r != CELL_EMPTY, below_r != CELL_EMPTY}
                       : 3'b000;

  always_comb begin
    count = 4'(left_live[0]) + 4'(left_live[1]) + 4'(left_live[2])
          + 4'(right_live[0]) + 4'(right_live[1]) + 4'(right_live[2])
          + 4'(live[0]) + 4'(live[2]);
    next_value = CELL_EMPTY;
    if (active) begin
      if (cur_r == CELL_IMMORTAL) begin
        next_value = CELL_IMMORTAL;
      end else if (cur_r == CELL_EMPTY && count == BIRTH_COUNT) begin
        next_value = CELL_ALIVE;
      end else if (cur_r == CELL_ALIVE && count >= SURVIVE_MIN && count <= BIRTH_COUNT) begin
        next_value = CELL_ALIVE;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/life_grid_generation_step.sv =====
// life grid generation step top level: row memory, cell chain and control
// A write or read passes through the ST_OP state before its registered result strobe. An advance sweeps the
// row memory once through a chain of MAX_COLS column cells holding a three-row window:
// one row is read and one row written back per cycle until the result strobe. After reset
// a clearing pass writes every row empty with busy high. Each accepted item except func
// three gives one result strobe for one cycle; func three is taken and dropped.
`default_nettype none
module life_grid_generation_step #(
  parameter int MAX_ROWS = lgs_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = lgs_pkg::MAX_COLS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_func,
  input  wire logic [7:0]  in_row,
  input  wire logic [7:0]  in_col,
  input  wire logic [1:0]  in_cell_value,
  output logic             out_valid,
  output logic [1:0]       out_read_value,
  output logic [1:0]       out_completed_op,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import lgs_pkg::*;

  localparam int AW  = $clog2(MAX_ROWS);
  localparam int CIW = $clog2(MAX_COLS);
  localparam int NW  = ($clog2(MAX_ROWS + 3) > 9) ? $clog2(MAX_ROWS + 3) : 9;
  localparam int CNW = ($clog2(MAX_COLS + 1) > 9) ? $clog2(MAX_COLS + 1) : 9;
  localparam int WW  = 2 * MAX_COLS;

  state_t          state_r, state_nxt;
  logic [NW-1:0]   k_r, k_nxt;
  logic [8:0]      rows_in_use_r, cols_in_use_r;
  logic [1:0]      op_func_r, op_func_nxt;
  logic            op_inside_r, op_inside_nxt;
  logic [CIW-1:0]  op_col_r, op_col_nxt;
  logic [AW-1:0]   op_row_r, op_row_nxt;
  logic [1:0]      op_val_r, op_val_nxt;
  logic            out_valid_nxt;
  logic [1:0]      out_read_value_nxt, out_completed_op_nxt;

  logic [NW-1:0]   nr;
  logic [CNW-1:0]  nc;
  logic [NW-1:0]   row_w;
  logic [CNW-1:0]  col_w;
  logic [NW-1:0]   k_m1, k_m3;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [WW-1:0]   ram_wdata, ram_rdata, cell_row;
  cell_ctrl_t      ctrl;
  logic [2:0]      live [MAX_COLS];
  logic [1:0]      nval [MAX_COLS];

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_COLS) ? {23'd0, cols_in_use_r} : {23'd0, rows_in_use_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_in_use_r <= ROWS_RESET;
      cols_in_use_r <= COLS_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_COLS) begin
        cols_in_use_r <= pwdata[8:0];
      end else begin
        rows_in_use_r <= pwdata[8:0];
      end
    end
  end

  assign nr = (NW'(rows_in_use_r) > NW'(MAX_ROWS)) ? NW'(MAX_ROWS) : NW'(rows_in_use_r);
  assign nc = (CNW'(cols_in_use_r) > CNW'(MAX_COLS)) ? CNW'(MAX_COLS) : CNW'(cols_in_use_r);
  assign row_w = NW'(in_row);
  assign col_w = CNW'(in_col);
  assign k_m1 = k_r - NW'(1);
  assign k_m3 = k_r - NW'(3);

  lgs_ram #(.WIDTH(WW), .DEPTH(MAX_ROWS)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  genvar gi;
  generate
    for (gi = 0; gi < MAX_COLS; gi++) begin : g_cell
      logic [2:0] left_l, right_l;
      if (gi == 0) begin : g_left_edge
        assign left_l = 3'b000;
      end else begin : g_left
        assign left_l = live[gi-1];
      end
      if (gi == MAX_COLS - 1) begin : g_right_edge
        assign right_l = 3'b000;
      end else begin : g_right
        assign right_l = live[gi+1];
      end
      assign cell_row[2*gi +: 2] = nval[gi];
      lgs_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .active    (CNW'(gi) < nc),
        .in_value  ((k_m1 < nr) ? ram_rdata[2*gi +: 2] : CELL_EMPTY),
        .left_live (left_l),
        .right_live(right_l),
        .live      (live[gi]),
        .next_value(nval[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      k_r       <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      k_r       <= k_nxt;
      out_valid <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_func_r        <= op_func_nxt;
    op_inside_r      <= op_inside_nxt;
    op_col_r         <= op_col_nxt;
    op_row_r         <= op_row_nxt;
    op_val_r         <= op_val_nxt;
    out_read_value   <= out_read_value_nxt;
    out_completed_op <= out_completed_op_nxt;
  end

  always_comb begin
    state_nxt            = state_r;
    k_nxt                = k_r;
    op_func_nxt          = op_func_r;
    op_inside_nxt        = op_inside_r;
    op_col_nxt           = op_col_r;
    op_row_nxt           = op_row_r;
    op_val_nxt           = op_val_r;
    out_valid_nxt        = 1'b0;
    out_read_value_nxt   = CELL_EMPTY;
    out_completed_op_nxt = op_func_r;
    busy                 = 1'b1;
    ram_we               = 1'b0;
    ram_waddr            = k_r[AW-1:0];
    ram_wdata            = '0;
    ram_raddr            = k_r[AW-1:0];
    ctrl                 = '0;
    case (state_r)
      ST_CLEAR: begin
        ram_we = 1'b1;
        k_nxt  = k_r + NW'(1);
        if (k_r == NW'(MAX_ROWS - 1)) begin
          k_nxt     = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy          = 1'b0;
        ram_raddr     = row_w[AW-1:0];
        op_func_nxt   = in_func;
        op_inside_nxt = (row_w < nr) && (col_w < nc);
        op_col_nxt    = col_w[CIW-1:0];
        op_row_nxt    = row_w[AW-1:0];
        op_val_nxt    = in_cell_value;
        if (start) begin
          case (in_func)
            FUNC_WRITE, FUNC_READ: state_nxt = ST_OP;
            FUNC_ADVANCE: begin
              ctrl.clear = 1'b1;
              k_nxt      = '0;
              state_nxt  = ST_ADV;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_OP: begin
        ram_waddr = op_row_r;
        ram_wdata = ram_rdata;
        ram_wdata[{op_col_r, 1'b0} +: 2] = op_val_r;
        if (op_func_r == FUNC_WRITE && op_inside_r && op_val_r <= CELL_IMMORTAL) begin
          ram_we = 1'b1;
        end
        if (op_func_r == FUNC_READ && op_inside_r) begin
          out_read_value_nxt = ram_rdata[{op_col_r, 1'b0} +: 2];
        end
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_ADV: begin
        ctrl.shift = (k_r >= NW'(1)) && (k_r <= NW'(MAX_ROWS + 1));
        ram_waddr  = k_m3[AW-1:0];
        ram_wdata  = (k_m3 < nr) ? cell_row : '0;
        ram_we     = (k_r >= NW'(3));
        k_nxt      = k_r + NW'(1);
        if (k_r == NW'(MAX_ROWS + 2)) begin
          k_nxt                = '0;
          out_valid_nxt        = 1'b1;
          out_completed_op_nxt = FUNC_ADVANCE;
          state_nxt            = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== design/lgs_checker.sv =====
// port-level checker for the life grid generation step and its bind
`default_nettype none
module lgs_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [1:0] in_func,
  input wire logic       out_valid,
  input wire logic [1:0] out_read_value,
  input wire logic [1:0] out_completed_op
);
  import lgs_pkg::*;

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  a_cell_op_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_func == FUNC_WRITE || in_func == FUNC_READ))
      |-> ##2 (out_valid && out_completed_op == $past(in_func, 2)))
    else $error("cell transaction result missing or wrong op");

  a_read_value_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_completed_op != FUNC_READ) |-> out_read_value == CELL_EMPTY)
    else $error("nonzero read value on non-read result");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy &&
     (in_func == FUNC_WRITE || in_func == FUNC_READ || in_func == FUNC_ADVANCE)) |=> busy)
    else $error("not busy after accepted transaction");

endmodule

bind life_grid_generation_step lgs_checker u_lgs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_func         (in_func),
  .out_valid       (out_valid),
  .out_read_value  (out_read_value),
  .out_completed_op(out_completed_op)
);
`default_nettype wire
